// File: rtl/oomq_pkg.sv
// ----------------------------------------------------------------------------
// oomq_pkg
// Types, sizes and codes of the overwrite-oldest message queue.
// ----------------------------------------------------------------------------
package oomq_pkg;

   localparam int RING_SLOTS     = 16;
   localparam int MAX_PAYLOAD    = 512;
   localparam int WORDS_PER_SLOT = (MAX_PAYLOAD + 7) / 8;
   localparam int STORE_DEPTH    = RING_SLOTS * WORDS_PER_SLOT;
   localparam int MAX_RESULTS    = 64;
   localparam int MAX_WORDS      = (WORDS_PER_SLOT < MAX_RESULTS) ? WORDS_PER_SLOT
                                                                 : MAX_RESULTS;
   localparam int MIN_CAPACITY   = 2;

   localparam int SLOT_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int COUNT_W = $clog2(RING_SLOTS + 1);
   localparam int OFF_W   = $clog2(WORDS_PER_SLOT + 1);
   localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int NW_W    = $clog2(MAX_WORDS + 1);

   localparam int DATA_W     = 64;
   localparam int MSGLEN_W   = 16;
   localparam int LEN_W      = 10;
   localparam int LENX_W     = LEN_W + 1;
   localparam int STATUS_W   = 3;
   localparam int VB_W       = 4;
   localparam int OCC_W      = 5;
   localparam int BYTES_PER_WORD = 8;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DATA   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPT = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_SMALL  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_DROP   = 3'd5;

   typedef struct packed {
      logic                mode;
      logic [DATA_W-1:0]   data_word;
      logic [MSGLEN_W-1:0] message_length;
      logic                last_word;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   payload_word;
      logic [VB_W-1:0]     valid_bytes;
      logic                last;
      logic [LEN_W-1:0]    entry_length;
      logic [OCC_W-1:0]    occupancy;
   } rsp_word_type;

endpackage

// File: rtl/oomq_ram.sv
// ----------------------------------------------------------------------------
// oomq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oomq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/overwrite_oldest_message_queue_core.sv
// ----------------------------------------------------------------------------
// overwrite_oldest_message_queue_core
// Ring of message slots; a full ring drops its oldest entry on a new push.
// ----------------------------------------------------------------------------
// A push word or a refused pop is taken while busy is low, and its single result
// strobes on rsp_valid in the next cycle, so push words stream one per cycle.
// A pop that returns data holds busy through ST_LEN and ST_DATA: ST_LEN reads
// the entry length from the length memory, then the payload memory delivers
// one word per cycle; the first data word leaves ST_DATA through the response
// register and the rest follow back to back. A pop that drops a too-long entry
// is busy only in ST_LEN, with its result in the cycle after. rsp_valid is a
// one-cycle strobe with no stall: the receiver must take every word as shown.
module overwrite_oldest_message_queue_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  oomq_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   output oomq_pkg::rsp_word_type rsp_word
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LEN  = 2'd1;
   localparam logic [1:0] ST_DATA = 2'd2;

   function automatic logic [oomq_pkg::SLOT_W-1:0] next_slot(
      input logic [oomq_pkg::SLOT_W-1:0] s);
      next_slot = (s == oomq_pkg::SLOT_W'(oomq_pkg::RING_SLOTS - 1))
                  ? '0 : s + oomq_pkg::SLOT_W'(1);
   endfunction

   function automatic logic [oomq_pkg::ADDR_W-1:0] addr_of(
      input logic [oomq_pkg::SLOT_W-1:0] slot, input int widx);
      addr_of = oomq_pkg::ADDR_W'(int'(slot) * oomq_pkg::WORDS_PER_SLOT + widx);
   endfunction

   logic [1:0]                      state_ff, state_in;
   logic [oomq_pkg::SLOT_W-1:0]     read_index_ff, read_index_in;
   logic [oomq_pkg::SLOT_W-1:0]     write_index_ff, write_index_in;
   logic [oomq_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [oomq_pkg::OFF_W-1:0]      offset_ff, offset_in;
   logic                            rejecting_ff, rejecting_in;
   logic [oomq_pkg::MSGLEN_W-1:0]   cap_ff, cap_in;
   logic [oomq_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [oomq_pkg::NW_W-1:0]       nwords_ff, nwords_in;
   logic [oomq_pkg::NW_W-1:0]       k_ff, k_in;
   logic [oomq_pkg::LEN_W-1:0]      rem_ff, rem_in;
   logic [oomq_pkg::LEN_W-1:0]      elen_ff, elen_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   oomq_pkg::rsp_word_type          rsp_ff, rsp_in;

   logic                            len_wr_en;
   logic [oomq_pkg::LEN_W-1:0]      len_wr_data;
   logic [oomq_pkg::LEN_W-1:0]      len_rd_data;
   logic                            pay_wr_en;
   logic [oomq_pkg::ADDR_W-1:0]     pay_wr_addr;
   logic [oomq_pkg::ADDR_W-1:0]     pay_rd_addr;
   logic [oomq_pkg::DATA_W-1:0]     pay_rd_data;

   logic                            accept;

   oomq_ram #(
      .WIDTH(oomq_pkg::LEN_W),
      .DEPTH(oomq_pkg::RING_SLOTS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (write_index_ff),
      .wr_data (len_wr_data),
      .rd_addr (read_index_ff),
      .rd_data (len_rd_data)
   );

   oomq_ram #(
      .WIDTH(oomq_pkg::DATA_W),
      .DEPTH(oomq_pkg::STORE_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (pay_wr_addr),
      .wr_data (req_word.data_word),
      .rd_addr (pay_rd_addr),
      .rd_data (pay_rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      logic                          first;
      logic                          bad_len;
      logic [oomq_pkg::LENX_W-1:0]   words_full;
      logic [oomq_pkg::VB_W-1:0]     vb;
      logic [oomq_pkg::DATA_W-1:0]   masked;
      logic                          is_last;

      state_in       = state_ff;
      read_index_in  = read_index_ff;
      write_index_in = write_index_ff;
      count_in       = count_ff;
      offset_in      = offset_ff;
      rejecting_in   = rejecting_ff;
      cap_in         = cap_ff;
      slot_in        = slot_ff;
      nwords_in      = nwords_ff;
      k_in           = k_ff;
      rem_in         = rem_ff;
      elen_in        = elen_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = '0;
      len_wr_en      = 1'b0;
      len_wr_data    = oomq_pkg::LEN_W'(req_word.message_length);
      pay_wr_en      = 1'b0;
      pay_wr_addr    = addr_of(write_index_ff, int'(offset_ff));
      pay_rd_addr    = addr_of(slot_ff, 0);

      first      = !rejecting_ff && (offset_ff == '0);
      bad_len    = (req_word.message_length == '0) ||
                   (int'(req_word.message_length) > oomq_pkg::MAX_PAYLOAD);
      words_full = '0;
      vb         = '0;
      masked     = '0;
      is_last    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_word.mode == oomq_pkg::MODE_PUSH) begin
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               if (first && bad_len) begin
                  rejecting_in  = !req_word.last_word;
                  rsp_in.status = oomq_pkg::STATUS_REJECT;
               end else if (rejecting_ff) begin
                  if (req_word.last_word) begin
                     rejecting_in = 1'b0;
                  end
                  rsp_in.status = oomq_pkg::STATUS_REJECT;
               end else begin
                  if (first) begin
                     if (count_ff >= oomq_pkg::COUNT_W'(oomq_pkg::RING_SLOTS)) begin
                        read_index_in = next_slot(read_index_ff);
                        count_in      = count_in - oomq_pkg::COUNT_W'(1);
                     end
                     len_wr_en = 1'b1;
                  end
                  if (offset_ff < oomq_pkg::OFF_W'(oomq_pkg::WORDS_PER_SLOT)) begin
                     pay_wr_en = 1'b1;
                     offset_in = offset_ff + oomq_pkg::OFF_W'(1);
                  end
                  if (req_word.last_word) begin
                     write_index_in = next_slot(write_index_ff);
                     count_in       = count_in + oomq_pkg::COUNT_W'(1);
                     offset_in      = '0;
                  end
                  rsp_in.status = oomq_pkg::STATUS_ACCEPT;
               end
               rsp_in.occupancy = oomq_pkg::OCC_W'(count_in);
            end else if (accept) begin
               if (int'(req_word.message_length) < oomq_pkg::MIN_CAPACITY) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.last      = 1'b1;
                  rsp_in.status    = oomq_pkg::STATUS_SMALL;
                  rsp_in.occupancy = oomq_pkg::OCC_W'(count_ff);
               end else if (count_ff == '0) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.last      = 1'b1;
                  rsp_in.status    = oomq_pkg::STATUS_EMPTY;
                  rsp_in.occupancy = oomq_pkg::OCC_W'(count_ff);
               end else begin
                  cap_in   = req_word.message_length;
                  slot_in  = read_index_ff;
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            read_index_in = next_slot(read_index_ff);
            count_in      = count_ff - oomq_pkg::COUNT_W'(1);
            if (oomq_pkg::MSGLEN_W'(len_rd_data) > cap_ff - oomq_pkg::MSGLEN_W'(1)) begin
               rsp_valid_in     = 1'b1;
               rsp_in.last      = 1'b1;
               rsp_in.status    = oomq_pkg::STATUS_DROP;
               rsp_in.occupancy = oomq_pkg::OCC_W'(count_in);
               state_in         = ST_IDLE;
            end else begin
               words_full = (oomq_pkg::LENX_W'(len_rd_data) + oomq_pkg::LENX_W'(7)) >> 3;
               nwords_in  = (words_full > oomq_pkg::LENX_W'(oomq_pkg::MAX_WORDS))
                            ? oomq_pkg::NW_W'(oomq_pkg::MAX_WORDS)
                            : oomq_pkg::NW_W'(words_full);
               rem_in      = len_rd_data;
               elen_in     = len_rd_data;
               k_in        = '0;
               pay_rd_addr = addr_of(slot_ff, 0);
               state_in    = ST_DATA;
            end
         end
         ST_DATA: begin
            vb = (rem_ff >= oomq_pkg::LEN_W'(oomq_pkg::BYTES_PER_WORD))
                 ? oomq_pkg::VB_W'(oomq_pkg::BYTES_PER_WORD) : oomq_pkg::VB_W'(rem_ff);
            for (int b = 0; b < oomq_pkg::BYTES_PER_WORD; b++) begin
               masked[b*8 +: 8] = (oomq_pkg::VB_W'(b) < vb) ? pay_rd_data[b*8 +: 8] : 8'h00;
            end
            is_last             = ((k_ff + oomq_pkg::NW_W'(1)) == nwords_ff);
            rsp_valid_in        = 1'b1;
            rsp_in.status       = oomq_pkg::STATUS_DATA;
            rsp_in.payload_word = masked;
            rsp_in.valid_bytes  = vb;
            rsp_in.last         = is_last;
            rsp_in.entry_length = elen_ff;
            rsp_in.occupancy    = oomq_pkg::OCC_W'(count_ff);
            rem_in              = rem_ff - oomq_pkg::LEN_W'(vb);
            if (is_last) begin
               state_in = ST_IDLE;
            end else begin
               k_in        = k_ff + oomq_pkg::NW_W'(1);
               pay_rd_addr = addr_of(slot_ff, int'(k_ff) + 1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         read_index_ff  <= '0;
         write_index_ff <= '0;
         count_ff       <= '0;
         offset_ff      <= '0;
         rejecting_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         read_index_ff  <= read_index_in;
         write_index_ff <= write_index_in;
         count_ff       <= count_in;
         offset_ff      <= offset_in;
         rejecting_ff   <= rejecting_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff    <= cap_in;
      slot_ff   <= slot_in;
      nwords_ff <= nwords_in;
      k_ff      <= k_in;
      rem_ff    <= rem_in;
      elen_ff   <= elen_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.occupancy <= oomq_pkg::OCC_W'(oomq_pkg::RING_SLOTS)))
      else $error("occupancy above slot count");

   a_push_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.mode == oomq_pkg::MODE_PUSH) |=>
      (rsp_valid && (rsp_word.status == oomq_pkg::STATUS_ACCEPT ||
                     rsp_word.status == oomq_pkg::STATUS_REJECT)))
      else $error("push word without answer in next cycle");

   a_data_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == oomq_pkg::STATUS_DATA) |->
      (rsp_word.valid_bytes != '0 &&
       rsp_word.valid_bytes <= oomq_pkg::VB_W'(oomq_pkg::BYTES_PER_WORD)))
      else $error("data word with bad byte count");

   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == oomq_pkg::STATUS_DATA) |->
      (rsp_word.last == !busy))
      else $error("busy out of step with pop stream");

endmodule
